FILE: rtl/rqit_pkg.sv
`timescale 1ns / 1ps

package rqit_pkg;

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 5;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = FUNC_W + TAG_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + TAG_W + 3 * CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Output field offsets
    localparam int OUT_RID_LSB      = STATUS_W;
    localparam int OUT_FLUSHED_LSB  = OUT_RID_LSB + TAG_W;
    localparam int OUT_PENDING_LSB  = OUT_FLUSHED_LSB + CNT_W;
    localparam int OUT_INFLIGHT_LSB = OUT_PENDING_LSB + CNT_W;

    localparam int DEF_PENDING_DEPTH  = 16;
    localparam int DEF_INFLIGHT_DEPTH = 16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_POST  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_STOP  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TAKE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_START = 3'd3;
    localparam logic [FUNC_W-1:0] FN_END   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } t_fifo_cmd;

    typedef struct packed {
        logic ins;
        logic rm;
    } t_tbl_cmd;

    typedef struct packed {
        logic full;
        logic found;
    } t_tbl_stat;

endpackage

FILE: rtl/rqit_pending.sv
`timescale 1ns / 1ps

// Pending tag FIFO: one write port, one registered read port at the head.
module rqit_pending
    import rqit_pkg::*;
#(
    parameter int PENDING_DEPTH = DEF_PENDING_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_fifo_cmd                             i_cmd,
    input  logic [TAG_W-1:0]                      i_tag,
    output logic [$clog2(PENDING_DEPTH+1)-1:0]    o_fill,
    output logic                                  o_full,
    output logic [TAG_W-1:0]                      o_rd_data
);

    localparam int PW = $clog2(PENDING_DEPTH);
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    logic [TAG_W-1:0] r_mem [PENDING_DEPTH];
    logic [PW-1:0]    r_head;
    logic [CW-1:0]    r_fill;
    logic [TAG_W-1:0] r_rd_data;

    logic [PW:0]   wsum;
    logic [PW:0]   wsum_wrap;
    logic [PW-1:0] wr_idx;
    logic [PW-1:0] n_head;

    // tail = (head + fill) mod depth; sum stays below twice the depth
    always_comb begin
        wsum = {1'b0, r_head} + (PW+1)'(r_fill);
        if (wsum >= (PW+1)'(PENDING_DEPTH)) begin
            wsum_wrap = wsum - (PW+1)'(PENDING_DEPTH);
        end else begin
            wsum_wrap = wsum;
        end
        wr_idx = i_cmd.flush ? '0 : wsum_wrap[PW-1:0];

        if (r_head == PW'(PENDING_DEPTH - 1)) begin
            n_head = '0;
        end else begin
            n_head = r_head + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_cmd.flush) begin
            r_head <= '0;
            r_fill <= CW'(1);
        end else if (i_cmd.push) begin
            r_fill <= r_fill + CW'(1);
        end else if (i_cmd.pop) begin
            r_head <= n_head;
            r_fill <= r_fill - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_idx] <= i_tag;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_fill    = r_fill;
    assign o_full    = (r_fill == CW'(PENDING_DEPTH));
    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rqit_inflight.sv
`timescale 1ns / 1ps

// In-flight tag table: parallel compare for lookup, lowest free slot on insert.
module rqit_inflight
    import rqit_pkg::*;
#(
    parameter int INFLIGHT_DEPTH = DEF_INFLIGHT_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_tbl_cmd                              i_cmd,
    input  logic [TAG_W-1:0]                      i_tag,
    output t_tbl_stat                             o_stat,
    output logic [$clog2(INFLIGHT_DEPTH+1)-1:0]   o_count
);

    localparam int IW = $clog2(INFLIGHT_DEPTH);
    localparam int KW = $clog2(INFLIGHT_DEPTH + 1);

    logic [TAG_W-1:0]          r_tags [INFLIGHT_DEPTH];
    logic [INFLIGHT_DEPTH-1:0] r_valid;
    logic [KW-1:0]             r_count;

    logic          free_hit;
    logic [IW-1:0] free_idx;
    logic          match_hit;
    logic [IW-1:0] match_idx;

    // Lowest free slot and lowest valid match; scan high to low so low wins
    always_comb begin
        free_hit  = 1'b0;
        free_idx  = '0;
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = INFLIGHT_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_hit = 1'b1;
                free_idx = IW'(i);
            end
            if (r_valid[i] && (r_tags[i] == i_tag)) begin
                match_hit = 1'b1;
                match_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.ins) begin
            r_valid[free_idx] <= 1'b1;
            r_count           <= r_count + KW'(1);
        end else if (i_cmd.rm) begin
            r_valid[match_idx] <= 1'b0;
            r_count            <= r_count - KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            r_tags[free_idx] <= i_tag;
        end
    end

    assign o_stat.full  = !free_hit;
    assign o_stat.found = match_hit;
    assign o_count      = r_count;

endmodule

FILE: rtl/request_queue_with_inflight_tracker.sv
// Pipeline: an accepted item passes the input register, then the result register, which drives the result.
// Throughput: one item per cycle; the result register is refilled in the same cycle it is
//   taken, so only downstream backpressure slows the block.
// Reset: i_rst_n synchronous, active low; empties the pending FIFO and the in-flight table,
//   returns to the running phase. Tag storage is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module request_queue_with_inflight_tracker
    import rqit_pkg::*;
#(
    parameter int PENDING_DEPTH  = DEF_PENDING_DEPTH,
    parameter int INFLIGHT_DEPTH = DEF_INFLIGHT_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input item: func [2:0], request_id [18:3], zero pad above
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Result item: status [2:0], result_id [18:3], flushed_count [23:19],
    //   pending_count [28:24], inflight_count [33:29], zero pad above
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int KW = $clog2(INFLIGHT_DEPTH + 1);

    // Stop sequence: running -> stopped (final tag posted) -> final tag started
    typedef enum logic [1:0] {
        PH_RUN,
        PH_STOPPED,
        PH_STARTED
    } t_phase;

    // Input register
    logic              r_in_valid;
    logic [FUNC_W-1:0] r_in_func;
    logic [TAG_W-1:0]  r_in_tag;

    // Result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [TAG_W-1:0]    r_out_rid;
    logic [CNT_W-1:0]    r_out_flushed;
    logic                r_out_take;   // result_id comes from the FIFO read port

    t_phase           r_phase;
    t_phase           n_phase;
    logic [TAG_W-1:0] r_final_tag;
    logic [TAG_W-1:0] n_final_tag;

    logic                n_status;
    logic [STATUS_W-1:0] n_out_status;
    logic [TAG_W-1:0]    n_rid;
    logic [CNT_W-1:0]    n_flushed;
    logic                n_take;

    logic s_accept;
    logic advance;

    t_fifo_cmd        fifo_cmd;
    logic [CW-1:0]    fifo_fill;
    logic             fifo_full;
    logic [TAG_W-1:0] fifo_rd_data;

    t_tbl_cmd      tbl_cmd;
    t_tbl_stat     tbl_stat;
    logic [KW-1:0] tbl_count;

    // The stage moves whenever it holds an item and the result slot is empty or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    rqit_pending #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_pending (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (fifo_cmd),
        .i_tag     (r_in_tag),
        .o_fill    (fifo_fill),
        .o_full    (fifo_full),
        .o_rd_data (fifo_rd_data)
    );

    rqit_inflight #(
        .INFLIGHT_DEPTH (INFLIGHT_DEPTH)
    ) u_inflight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .i_tag   (r_in_tag),
        .o_stat  (tbl_stat),
        .o_count (tbl_count)
    );

    // Operation decode. Commands to the FIFO and table fire only when the stage advances.
    always_comb begin
        n_status     = 1'b0;
        n_out_status = ST_OK;
        n_rid        = '0;
        n_flushed    = '0;
        n_take       = 1'b0;
        n_phase      = r_phase;
        n_final_tag  = r_final_tag;
        fifo_cmd     = '0;
        tbl_cmd      = '0;

        case (r_in_func)
            FN_POST: begin
                if (r_phase != PH_RUN) begin
                    n_out_status = ST_STOPPED;
                end else if (fifo_full) begin
                    n_out_status = ST_FULL;
                end else begin
                    fifo_cmd.push = 1'b1;
                end
            end
            FN_STOP: begin
                if (r_phase != PH_RUN) begin
                    n_out_status = ST_STOPPED;
                end else begin
                    // discard everything pending, then queue the final tag in slot 0
                    n_flushed      = CNT_W'(fifo_fill);
                    fifo_cmd.flush = 1'b1;
                    fifo_cmd.push  = 1'b1;
                    n_final_tag    = r_in_tag;
                    n_phase        = PH_STOPPED;
                end
            end
            FN_TAKE: begin
                if ((r_phase != PH_RUN) && (tbl_count != '0)) begin
                    n_out_status = ST_BLOCKED;
                end else if (fifo_fill == '0) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    fifo_cmd.pop = 1'b1;
                    n_take       = 1'b1;
                end
            end
            FN_START: begin
                if ((r_phase == PH_STARTED) ||
                    ((r_phase == PH_STOPPED) && (r_in_tag != r_final_tag))) begin
                    n_out_status = ST_STOPPED;
                end else if (tbl_stat.full) begin
                    n_out_status = ST_FULL;
                end else begin
                    tbl_cmd.ins = 1'b1;
                    if (r_phase == PH_STOPPED) begin
                        n_phase = PH_STARTED;
                    end
                end
            end
            FN_END: begin
                if (tbl_stat.found) begin
                    tbl_cmd.rm = 1'b1;
                    n_rid      = r_in_tag;
                end else begin
                    n_out_status = ST_NOTFOUND;
                end
            end
            default: begin
                // unused codes: no state change, ok status
                n_status = 1'b1;
            end
        endcase

        if (!advance) begin
            fifo_cmd = '0;
            tbl_cmd  = '0;
        end
    end

    // Control state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_RUN;
            r_final_tag <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_final_tag <= n_final_tag;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_func <= s_axis_tdata[FUNC_W-1:0];
            r_in_tag  <= s_axis_tdata[FUNC_W +: TAG_W];
        end
        if (advance) begin
            r_out_status  <= n_status ? ST_OK : n_out_status;
            r_out_rid     <= n_rid;
            r_out_flushed <= n_flushed;
            r_out_take    <= n_take;
        end
    end

    // Occupancy counts and the FIFO read data are live registers that only change when a
    // new result is loaded, so they hold with the result while it waits.
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[STATUS_W-1:0]              = r_out_status;
        m_axis_tdata[OUT_RID_LSB +: TAG_W]      = r_out_take ? fifo_rd_data : r_out_rid;
        m_axis_tdata[OUT_FLUSHED_LSB +: CNT_W]  = r_out_flushed;
        m_axis_tdata[OUT_PENDING_LSB +: CNT_W]  = CNT_W'(fifo_fill);
        m_axis_tdata[OUT_INFLIGHT_LSB +: CNT_W] = CNT_W'(tbl_count);
    end

    assign m_axis_tvalid = r_out_valid;

endmodule

FILE: rtl/rqit_checker.sv
`timescale 1ns / 1ps

module rqit_checker
    import rqit_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    rid;
    logic [CNT_W-1:0]    pending;

    assign status  = m_axis_tdata[STATUS_W-1:0];
    assign rid     = m_axis_tdata[OUT_RID_LSB +: TAG_W];
    assign pending = m_axis_tdata[OUT_PENDING_LSB +: CNT_W];

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> status <= ST_NOTFOUND)
        else $error("status code out of range");

    a_rid_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (status != ST_OK) |-> rid == '0)
        else $error("result_id set on a failed operation");

    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (status == ST_EMPTY) |-> pending == '0)
        else $error("empty status with pending tags");

endmodule

bind request_queue_with_inflight_tracker rqit_checker u_rqit_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
